[hdl/stmh_pkg.sv]
// stmh_pkg: shared types and constants for the text hash block.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps
package stmh_pkg;

    localparam int CHAR_W  = 8;
    localparam int HCHR_W  = 7;
    localparam int ACC_W   = 48;
    localparam int QDEPTH  = 4;

    localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

    // prime 2^48 - 59; 2^48 folds back as 59
    localparam logic [ACC_W-1:0] PRIME = 48'hFFFF_FFFF_FFC5;
    localparam logic [5:0]       FOLD  = 6'd59;

    typedef enum logic [0:0] {
        OP_SKIP = 1'b0,
        OP_HASH = 1'b1
    } t_op;

    // one word handed from front to back
    typedef struct packed {
        t_op               op;
        logic [HCHR_W-1:0] chr;
        logic              last;
    } t_word;

endpackage

[hdl/schema_text_hash_mod_prime_core.sv]
// Text hash mod 2^48-59: the last character passes the queue register, then
// the digest register, before o_out_valid. The front takes one character per
// cycle while the queue is not full; the accumulator update (shift, fold by
// 59, one conditional subtract) is combinational. A held digest stalls the
// queue once the next last character is at its head; later words wait there.
// Synchronous active-low reset clears accumulator, comment flag, queue, valid.
`timescale 1ns / 1ps
module schema_text_hash_mod_prime_core
    import stmh_pkg::*;
#(
    parameter int QUEUE_DEPTH = QDEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // character words in
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    // digest words out
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ACC_W-1:0]  o_digest
);

    logic  accept;
    logic  push;
    t_word push_word;
    logic  q_full;
    logic  q_valid;
    t_word q_head;
    logic  pop;

    // the front end never stalls except when the queue is full
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    // front: comment tracking and classification; drops skipped non-last words
    stmh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_push      (push),
        .o_word      (push_word)
    );

    // decoupling queue: lets the front keep taking words while a digest waits
    stmh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // back: modular accumulate and digest output register
    stmh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_digest    (o_digest)
    );

endmodule

[hdl/stmh_front.sv]
// stmh_front: accepts characters, tracks comments, classifies each word.
// Depends on stmh_pkg.
`timescale 1ns / 1ps
module stmh_front
    import stmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    output logic              o_push,
    output t_word             o_word
);

    logic r_in_comment;
    logic n_in_comment;
    t_op  op;

    always_comb begin
        op           = OP_SKIP;
        n_in_comment = r_in_comment;
        if (r_in_comment) begin
            if (i_char_code == CH_LF) begin
                n_in_comment = 1'b0;
            end
        end else if (i_char_code inside {CH_SP, CH_TAB, CH_LF}) begin
            op = OP_SKIP;
        end else if (i_char_code == CH_STAR) begin
            n_in_comment = 1'b1;
        end else begin
            op = OP_HASH;
        end
        if (i_last_char) begin
            n_in_comment = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
        end else if (i_accept) begin
            r_in_comment <= n_in_comment;
        end
    end

    // skipped words that do not end the text carry nothing for the back end
    assign o_push      = i_accept && ((op == OP_HASH) || i_last_char);
    assign o_word.op   = op;
    assign o_word.chr  = i_char_code[HCHR_W-1:0];
    assign o_word.last = i_last_char;

    a_last_clears_comment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_char) |=> !r_in_comment)
        else $error("comment flag survived end of text");

endmodule

[hdl/stmh_queue.sv]
// stmh_queue: short register FIFO between front and back ends.
// Depends on stmh_pkg.
`timescale 1ns / 1ps
module stmh_queue
    import stmh_pkg::*;
#(
    parameter int DEPTH = QDEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_word o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_word             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

[hdl/stmh_back.sv]
// stmh_back: folds hashed characters into the accumulator, holds the digest.
// Depends on stmh_pkg.
`timescale 1ns / 1ps
module stmh_back
    import stmh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_word            i_q_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ACC_W-1:0] o_digest
);

    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       r_digest;
    logic                   r_out_valid;
    logic [ACC_W+HCHR_W-1:0] shifted;
    logic [ACC_W:0]         folded;
    logic [ACC_W-1:0]       stepped;
    logic [ACC_W-1:0]       n_acc;

    // acc*128 + c, then the 7 bits above 2^48 fold back times 59;
    // the fold stays below twice the prime, so one subtract reduces it
    always_comb begin
        shifted = {r_acc, i_q_head.chr};
        folded  = {1'b0, shifted[ACC_W-1:0]}
                + ((ACC_W+1)'(shifted[ACC_W+HCHR_W-1:ACC_W]) * (ACC_W+1)'(FOLD));
        if (folded >= {1'b0, PRIME}) begin
            stepped = ACC_W'(folded - {1'b0, PRIME});
        end else begin
            stepped = folded[ACC_W-1:0];
        end
        n_acc = (i_q_head.op == OP_HASH) ? stepped : r_acc;
    end

    assign o_pop = i_q_valid && (!i_q_head.last || !r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc <= i_q_head.last ? '0 : n_acc;
            end
            if (o_pop && i_q_head.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_head.last) begin
            r_digest <= n_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digest    = r_digest;

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < PRIME)
        else $error("accumulator not reduced");

    a_digest_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_head.last) |=> (r_digest < PRIME) && r_acc == '0)
        else $error("digest not reduced or accumulator not cleared");

endmodule
